### rtl/core/plr_pkg.sv
// Package with the shared types, codes and CRC function of the packet link receiver.
`default_nettype none
package plr_pkg;
   localparam int PAYLOAD_BYTES_DEF = 16;
   localparam int RING_SLOTS_DEF = 8;

   localparam logic [1:0] CSR_POLY = 2'd0;
   localparam logic [1:0] CSR_INIT = 2'd1;
   localparam logic [1:0] CSR_RETX = 2'd2;
   localparam logic [1:0] CSR_ACK = 2'd3;

   localparam logic [1:0] KIND_TX = 2'd0;
   localparam logic [1:0] KIND_POP = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_CTL = 3'd1;
   localparam logic [2:0] MODE_REPLAY = 3'd2;
   localparam logic [2:0] MODE_POP = 3'd3;
   localparam logic [2:0] MODE_EMPTY = 3'd4;

   localparam logic [1:0] PHASE_LENGTH = 2'd0;
   localparam logic [1:0] PHASE_PAYLOAD = 2'd1;
   localparam logic [1:0] PHASE_CRC = 2'd2;

   localparam logic [7:0] FILL_BYTE = 8'hFF;
   localparam logic [7:0] CTL_LENGTH = 8'h01;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic       dropped_full;
      logic       frames_waiting;
   } rsp_type;

   typedef struct packed {
      logic [7:0] crc_polynomial;
      logic [7:0] crc_initial;
      logic [7:0] retransmit_code;
      logic [7:0] ack_code;
   } cfg_type;

   typedef struct packed {
      logic       start;
      logic [2:0] mode;
      logic [7:0] code;
      logic       dropped;
      logic       fw;
   } cmd_type;

   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ poly) : (c << 1);
      end
      return c;
   endfunction
endpackage
`default_nettype wire

### rtl/core/plr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module plr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 144
) (
   input  wire                     clock,
   input  wire                     we,
   input  wire [$clog2(DEPTH)-1:0] waddr,
   input  wire [WIDTH-1:0]         wdata,
   input  wire [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]        rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### rtl/core/plr_rx.sv
// Receive framing, CRC check, frame decode and ring pointers.
`default_nettype none
module plr_rx import plr_pkg::*; #(
   parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
   parameter int RING_SLOTS = RING_SLOTS_DEF,
   parameter int FB = PAYLOAD_BYTES + 2,
   parameter int AW = $clog2(RING_SLOTS * FB)
) (
   input  wire             clock,
   input  wire             reset,
   input  cfg_type         cfg,
   input  wire             accept,
   input  req_type         req,
   output logic            ram_we,
   output logic [AW-1:0]   ram_waddr,
   output logic [7:0]      ram_wdata,
   output logic [AW-1:0]   pop_base,
   output cmd_type         cmd
);
   localparam int CW = $clog2(PAYLOAD_BYTES > 1 ? PAYLOAD_BYTES : 2);
   localparam int SW = $clog2(RING_SLOTS);
   localparam int IW = $clog2(FB);

   logic [1:0]    phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    crc_ff, crc_in;
   logic          len_ok_ff, len_ok_in;
   logic [7:0]    code_ff, code_in;
   logic          all_ff_ff, all_ff_in;
   logic [SW-1:0] rd_slot_ff, rd_slot_in, wr_slot_ff, wr_slot_in, wr_next;
   logic [AW-1:0] rd_base_ff, rd_base_in, wr_base_ff, wr_base_in;
   logic [IW-1:0] idx;
   logic          ctl;

   assign wr_next = (wr_slot_ff == SW'(RING_SLOTS - 1)) ? '0 : wr_slot_ff + 1'b1;
   assign ctl = len_ok_ff && all_ff_ff;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      crc_in = crc_ff;
      len_ok_in = len_ok_ff;
      code_in = code_ff;
      all_ff_in = all_ff_ff;
      rd_slot_in = rd_slot_ff;
      wr_slot_in = wr_slot_ff;
      rd_base_in = rd_base_ff;
      wr_base_in = wr_base_ff;
      idx = '0;
      cmd = '0;
      if (accept) begin
         if (req.op) begin
            cmd.start = 1'b1;
            if (rd_slot_ff == wr_slot_ff) begin
               cmd.mode = MODE_EMPTY;
            end else begin
               cmd.mode = MODE_POP;
               if (rd_slot_ff == SW'(RING_SLOTS - 1)) begin
                  rd_slot_in = '0;
                  rd_base_in = '0;
               end else begin
                  rd_slot_in = rd_slot_ff + 1'b1;
                  rd_base_in = rd_base_ff + AW'(FB);
               end
            end
         end else begin
            unique case (phase_ff)
               PHASE_PAYLOAD: begin
                  idx = IW'(count_ff) + 1'b1;
                  crc_in = crc_byte(crc_ff, req.rx_byte, cfg.crc_polynomial);
                  if (count_ff == '0) begin
                     code_in = req.rx_byte;
                  end else begin
                     all_ff_in = all_ff_ff && (req.rx_byte == FILL_BYTE);
                  end
                  if (count_ff == CW'(PAYLOAD_BYTES - 1)) begin
                     count_in = '0;
                     phase_in = PHASE_CRC;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
               PHASE_CRC: begin
                  idx = IW'(FB - 1);
                  phase_in = PHASE_LENGTH;
                  if (req.rx_byte != crc_ff) begin
                     cmd.start = 1'b1;
                     cmd.mode = MODE_CTL;
                     cmd.code = cfg.retransmit_code;
                  end else if (ctl && code_ff == cfg.retransmit_code) begin
                     cmd.start = 1'b1;
                     cmd.mode = MODE_REPLAY;
                  end else if (!(ctl && code_ff == cfg.ack_code)) begin
                     cmd.start = 1'b1;
                     cmd.mode = MODE_CTL;
                     cmd.code = cfg.ack_code;
                     if (wr_next == rd_slot_ff) begin
                        cmd.dropped = 1'b1;
                     end else begin
                        wr_slot_in = wr_next;
                        wr_base_in = (wr_next == '0) ? '0 : wr_base_ff + AW'(FB);
                     end
                  end
               end
               default: begin
                  idx = '0;
                  len_ok_in = (req.rx_byte == CTL_LENGTH);
                  crc_in = crc_byte(cfg.crc_initial, req.rx_byte, cfg.crc_polynomial);
                  count_in = '0;
                  all_ff_in = 1'b1;
                  phase_in = PHASE_PAYLOAD;
               end
            endcase
         end
      end
      cmd.fw = (rd_slot_in != wr_slot_in);
   end

   assign ram_we = accept && !req.op;
   assign ram_waddr = wr_base_ff + AW'(idx);
   assign ram_wdata = req.rx_byte;
   assign pop_base = rd_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_LENGTH;
         count_ff <= '0;
         crc_ff <= cfg.crc_initial;
         rd_slot_ff <= '0;
         wr_slot_ff <= '0;
         rd_base_ff <= '0;
         wr_base_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         crc_ff <= crc_in;
         rd_slot_ff <= rd_slot_in;
         wr_slot_ff <= wr_slot_in;
         rd_base_ff <= rd_base_in;
         wr_base_ff <= wr_base_in;
      end
      len_ok_ff <= len_ok_in;
      code_ff <= code_in;
      all_ff_ff <= all_ff_in;
   end
endmodule
`default_nettype wire

### rtl/core/plr_seq.sv
// Output sequencer that drains transmit frames and popped frames into the result register.
`default_nettype none
module plr_seq import plr_pkg::*; #(
   parameter int FB = PAYLOAD_BYTES_DEF + 2,
   parameter int AW = $clog2(RING_SLOTS_DEF * FB)
) (
   input  wire           clock,
   input  wire           reset,
   input  cfg_type       cfg,
   input  cmd_type       cmd,
   input  wire [AW-1:0]  cmd_base,
   input  wire [7:0]     ram_rdata,
   output logic [AW-1:0] ram_raddr,
   output logic          idle,
   output logic          rsp_valid,
   input  wire           rsp_ready,
   output rsp_type       rsp_payload
);
   localparam int IW = $clog2(FB);

   logic [2:0]    mode_ff, mode_in;
   logic [IW-1:0] k_ff, k_in;
   logic [7:0]    code_ff, code_in, crc_ff, crc_in;
   logic          zero_ff, zero_in, fixed_ff, fixed_in, drop_ff, drop_in, fw_ff, fw_in;
   logic [AW-1:0] base_ff, base_in;
   logic          last_ctl_ff, last_ctl_in;
   logic [7:0]    last_code_ff, last_code_in, last_crc_ff, last_crc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          load, final_byte;
   logic [7:0]    tx_byte;

   assign idle = (mode_ff == MODE_IDLE);
   assign load = !idle && (!rsp_valid_ff || rsp_ready);
   assign final_byte = (mode_ff == MODE_EMPTY) || (k_ff == IW'(FB - 1));

   always_comb begin
      if (zero_ff) begin
         tx_byte = '0;
      end else if (k_ff == '0) begin
         tx_byte = CTL_LENGTH;
      end else if (k_ff == IW'(1)) begin
         tx_byte = code_ff;
      end else if (k_ff == IW'(FB - 1)) begin
         tx_byte = fixed_ff ? last_crc_ff : crc_ff;
      end else begin
         tx_byte = FILL_BYTE;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      k_in = k_ff;
      code_in = code_ff;
      crc_in = crc_ff;
      zero_in = zero_ff;
      fixed_in = fixed_ff;
      drop_in = drop_ff;
      fw_in = fw_ff;
      base_in = base_ff;
      last_ctl_in = last_ctl_ff;
      last_code_in = last_code_ff;
      last_crc_in = last_crc_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_in = rsp_ff;
      if (cmd.start) begin
         mode_in = cmd.mode;
         k_in = '0;
         crc_in = cfg.crc_initial;
         drop_in = cmd.dropped;
         fw_in = cmd.fw;
         base_in = cmd_base;
         if (cmd.mode == MODE_REPLAY) begin
            code_in = last_code_ff;
            zero_in = !last_ctl_ff;
            fixed_in = 1'b1;
         end else begin
            code_in = cmd.code;
            zero_in = 1'b0;
            fixed_in = 1'b0;
         end
         if (cmd.mode == MODE_CTL) begin
            last_ctl_in = 1'b1;
            last_code_in = cmd.code;
         end
      end else if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in.last = final_byte;
         rsp_in.dropped_full = drop_ff;
         rsp_in.frames_waiting = fw_ff;
         unique case (mode_ff)
            MODE_POP: begin
               rsp_in.kind = KIND_POP;
               rsp_in.data = ram_rdata;
            end
            MODE_EMPTY: begin
               rsp_in.kind = KIND_EMPTY;
               rsp_in.data = '0;
            end
            default: begin
               rsp_in.kind = KIND_TX;
               rsp_in.data = tx_byte;
            end
         endcase
         if (mode_ff == MODE_CTL) begin
            if (final_byte) begin
               last_crc_in = crc_ff;
            end else begin
               crc_in = crc_byte(crc_ff, tx_byte, cfg.crc_polynomial);
            end
         end
         if (final_byte) begin
            mode_in = MODE_IDLE;
            k_in = '0;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   assign ram_raddr = base_in + AW'(k_in);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         k_ff <= '0;
         last_ctl_ff <= 1'b0;
         last_code_ff <= '0;
         last_crc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         k_ff <= k_in;
         last_ctl_ff <= last_ctl_in;
         last_code_ff <= last_code_in;
         last_crc_ff <= last_crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff <= code_in;
      crc_ff <= crc_in;
      zero_ff <= zero_in;
      fixed_ff <= fixed_in;
      drop_ff <= drop_in;
      fw_ff <= fw_in;
      base_ff <= base_in;
      rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

### rtl/core/packet_link_receiver_with_ack_retransmit_core.sv
// Top level of the CRC-8 framed packet receiver with acknowledge and retransmit.
// Length and payload bytes are accepted one per cycle while idle and give no result.
// A CRC byte (save that of a good ack frame) or a pop starts a burst of PAYLOAD_BYTES+2
// results (one for an empty pop), one per cycle from the sequencer while rsp_ready allows;
// input waits until the burst is loaded. The first result follows the mode register load.
// Synchronous reset clears framing, ring pointers, the last sent frame and result valid.
`default_nettype none
module packet_link_receiver_with_ack_retransmit_core import plr_pkg::*; #(
   parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
   parameter int RING_SLOTS = RING_SLOTS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output rsp_type    rsp_payload,
   input  wire        csr_we,
   input  wire [1:0]  csr_index,
   input  wire [7:0]  csr_wdata
);
   localparam int FB = PAYLOAD_BYTES + 2;
   localparam int DEPTH = RING_SLOTS * FB;
   localparam int AW = $clog2(DEPTH);

   cfg_type       cfg_ff, cfg_in;
   cmd_type       cmd;
   logic          accept, idle, ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr, pop_base;
   logic [7:0]    ram_wdata, ram_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_POLY: cfg_in.crc_polynomial = csr_wdata;
            CSR_INIT: cfg_in.crc_initial = csr_wdata;
            CSR_RETX: cfg_in.retransmit_code = csr_wdata;
            CSR_ACK:  cfg_in.ack_code = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{crc_polynomial: 8'd7, crc_initial: 8'd0,
                     retransmit_code: 8'd25, ack_code: 8'd21};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = idle;
   assign accept = req_valid && req_ready;

   plr_rx #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES),
      .RING_SLOTS(RING_SLOTS),
      .FB(FB),
      .AW(AW)
   ) u_rx (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .accept(accept),
      .req(req_payload),
      .ram_we(ram_we),
      .ram_waddr(ram_waddr),
      .ram_wdata(ram_wdata),
      .pop_base(pop_base),
      .cmd(cmd)
   );

   plr_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_ring (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   plr_seq #(
      .FB(FB),
      .AW(AW)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .cmd(cmd),
      .cmd_base(pop_base),
      .ram_rdata(ram_rdata),
      .ram_raddr(ram_raddr),
      .idle(idle),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );
endmodule
`default_nettype wire

### rtl/core/plr_checker.sv
// Port-level checker for the packet link receiver and its bind statement.
`default_nettype none
module plr_checker import plr_pkg::*; (
   input wire     clock,
   input wire     reset,
   input wire     req_ready,
   input wire     rsp_valid,
   input wire     rsp_ready,
   input rsp_type rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_EMPTY |-> rsp_payload.last
         && rsp_payload.data == 8'd0)
      else $error("empty pop result malformed");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.kind != 2'd3)
      else $error("illegal result kind");

   a_burst_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> !req_ready)
      else $error("input taken in the middle of a burst");
endmodule

bind packet_link_receiver_with_ack_retransmit_core plr_checker u_plr_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_payload(rsp_payload)
);
`default_nettype wire

### bench/tb_packet_link_receiver_with_ack_retransmit_core.sv
// Testbench for the packet link receiver: framed traffic, acks, retransmits and pops, self-checked.
`timescale 1ns / 1ps
module tb_packet_link_receiver_with_ack_retransmit_core;
   import plr_pkg::*;

   localparam int PB = PAYLOAD_BYTES_DEF;
   localparam int SLOTS = RING_SLOTS_DEF;
   localparam int FB = PB + 2;
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_POP = 1'b1;
   localparam longint CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   packet_link_receiver_with_ack_retransmit_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   cfg_type link_cfg;
   logic [1:0] rx_phase;
   int payload_count;
   logic [7:0] rx_frame [PB+1];
   logic [7:0] running_crc;
   logic [7:0] last_sent [FB];
   logic [7:0] ring [SLOTS][FB];
   int read_slot, write_slot;
   rsp_type expected_rsp [$];
   int errors = 0;
   longint cycle_count = 0;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int hold_off = 0;

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++)
         c = c[7] ? ((c << 1) ^ link_cfg.crc_polynomial) : (c << 1);
      return c;
   endfunction

   function automatic void build_control(output logic [7:0] f [FB], input logic [7:0] code);
      logic [7:0] c;
      c = link_cfg.crc_initial;
      for (int i = 0; i < FB; i++) f[i] = FILL_BYTE;
      f[0] = CTL_LENGTH;
      f[1] = code;
      for (int i = 0; i <= PB; i++) c = crc_step(c, f[i]);
      f[FB-1] = c;
   endfunction

   function automatic bit is_control(logic [7:0] f [FB], logic [7:0] code);
      if (f[0] != CTL_LENGTH || f[1] != code) return 0;
      for (int i = 2; i <= PB; i++) if (f[i] != FILL_BYTE) return 0;
      return 1;
   endfunction

   function automatic void queue_frame(logic [1:0] kind, logic [7:0] f [FB], int n,
                                       bit dropped);
      rsp_type r;
      for (int k = 0; k < n; k++) begin
         r.kind = kind;
         r.data = (kind == KIND_EMPTY) ? 8'h00 : f[k];
         r.last = (k == n - 1);
         r.dropped_full = dropped;
         r.frames_waiting = (read_slot != write_slot);
         expected_rsp.push_back(r);
      end
   endfunction

   function automatic void predict_link(req_type it);
      logic [7:0] f [FB];
      int nx;
      if (it.op == OP_POP) begin
         if (read_slot == write_slot) begin
            queue_frame(KIND_EMPTY, f, 1, 0);
         end else begin
            f = ring[read_slot];
            read_slot = (read_slot + 1) % SLOTS;
            queue_frame(KIND_POP, f, FB, 0);
         end
      end else if (rx_phase == PHASE_PAYLOAD) begin
         rx_frame[1 + payload_count] = it.rx_byte;
         running_crc = crc_step(running_crc, it.rx_byte);
         payload_count++;
         if (payload_count >= PB) begin
            payload_count = 0;
            rx_phase = PHASE_CRC;
         end
      end else if (rx_phase == PHASE_CRC) begin
         rx_phase = PHASE_LENGTH;
         for (int i = 0; i <= PB; i++) f[i] = rx_frame[i];
         f[FB-1] = it.rx_byte;
         if (it.rx_byte != running_crc) begin
            build_control(last_sent, link_cfg.retransmit_code);
            queue_frame(KIND_TX, last_sent, FB, 0);
         end else if (is_control(f, link_cfg.retransmit_code)) begin
            queue_frame(KIND_TX, last_sent, FB, 0);
         end else if (!is_control(f, link_cfg.ack_code)) begin
            nx = (write_slot + 1) % SLOTS;
            if (nx != read_slot) begin
               ring[write_slot] = f;
               write_slot = nx;
            end
            build_control(last_sent, link_cfg.ack_code);
            queue_frame(KIND_TX, last_sent, FB, nx == read_slot);
         end
      end else begin
         rx_frame[0] = it.rx_byte;
         running_crc = crc_step(link_cfg.crc_initial, it.rx_byte);
         payload_count = 0;
         rx_phase = PHASE_PAYLOAD;
      end
   endfunction

   // Valid stays high from one transfer into the next unless the sender idles.
   task automatic send_item(logic op, logic [7:0] b);
      req_type it;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      it.op = op;
      it.rx_byte = b;
      req_payload <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_link(it);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_payload);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_payload !== want) begin
               $display("%0t: mismatch expected kind=%0d data=%h last=%b drop=%b fw=%b",
                        $time, want.kind, want.data, want.last, want.dropped_full,
                        want.frames_waiting);
               $display("%0t:          actual kind=%0d data=%h last=%b drop=%b fw=%b",
                        $time, rsp_payload.kind, rsp_payload.data, rsp_payload.last,
                        rsp_payload.dropped_full, rsp_payload.frames_waiting);
               errors++;
            end
         end
      end
   end

   task automatic drain_link;
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_POLY: link_cfg.crc_polynomial = v;
         CSR_INIT: link_cfg.crc_initial = v;
         CSR_RETX: link_cfg.retransmit_code = v;
         default: link_cfg.ack_code = v;
      endcase
      @(negedge clock);
   endtask

   // Sends a whole frame; good selects a correct CRC, otherwise the CRC is flipped.
   task automatic send_frame(logic [7:0] body [PB+1], bit good);
      logic [7:0] c;
      c = link_cfg.crc_initial;
      for (int i = 0; i <= PB; i++) begin
         c = crc_step(c, body[i]);
         send_item(OP_BYTE, body[i]);
      end
      send_item(OP_BYTE, good ? c : ~c);
   endtask

   task automatic send_random_frame(bit good);
      logic [7:0] body [PB+1];
      for (int i = 0; i <= PB; i++) body[i] = 8'($urandom_range(255));
      send_frame(body, good);
   endtask

   task automatic send_control_frame(logic [7:0] code);
      logic [7:0] body [PB+1];
      for (int i = 0; i <= PB; i++) body[i] = FILL_BYTE;
      body[0] = CTL_LENGTH;
      body[1] = code;
      send_frame(body, 1);
   endtask

   task automatic test_directed;
      logic [7:0] body [PB+1];
      send_item(OP_POP, 8'h00);
      send_control_frame(link_cfg.retransmit_code);
      for (int i = 0; i <= PB; i++) body[i] = 8'h00;
      send_frame(body, 1);
      for (int i = 0; i <= PB; i++) body[i] = 8'hFF;
      send_frame(body, 1);
      send_random_frame(0);
      send_control_frame(link_cfg.ack_code);
      send_item(OP_BYTE, 8'h55);
      send_item(OP_POP, 8'hAA);
      send_item(OP_BYTE, 8'h12);
      send_item(OP_POP, 8'h00);
      // Finish the partial frame so later tests start at a frame boundary.
      while (rx_phase != PHASE_LENGTH) send_item(OP_BYTE, 8'($urandom_range(255)));
      drain_link();
   endtask

   task automatic test_ring_full;
      for (int i = 0; i < SLOTS + 1; i++) send_random_frame(1);
      for (int i = 0; i < SLOTS + 1; i++) send_item(OP_POP, 8'($urandom_range(255)));
      drain_link();
   endtask

   task automatic test_backpressure;
      hold_off = 400;
      send_random_frame(1);
      send_item(OP_POP, 8'h00);
      send_item(OP_POP, 8'h00);
      drain_link();
   endtask

   task automatic test_random(int n_items);
      int sent;
      int r;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(99);
         if (r < 50) begin
            send_random_frame(1);
            sent += FB;
         end else if (r < 60) begin
            send_random_frame(0);
            sent += FB;
         end else if (r < 68) begin
            send_control_frame(link_cfg.retransmit_code);
            sent += FB;
         end else if (r < 74) begin
            send_control_frame(link_cfg.ack_code);
            sent += FB;
         end else begin
            send_item(OP_POP, 8'($urandom_range(255)));
            sent++;
         end
      end
      // Finish any partial frame so the block ends at a frame boundary.
      while (rx_phase != PHASE_LENGTH) begin
         send_item(OP_BYTE, 8'($urandom_range(255)));
         sent++;
      end
      drain_link();
   endtask

   task automatic test_config_sweep;
      write_csr(CSR_POLY, 8'hFF);
      write_csr(CSR_INIT, 8'hFF);
      write_csr(CSR_RETX, 8'h00);
      write_csr(CSR_ACK, 8'hFF);
      test_random(30);
      write_csr(CSR_POLY, 8'h00);
      write_csr(CSR_INIT, 8'h00);
      write_csr(CSR_RETX, 8'hFF);
      write_csr(CSR_ACK, 8'h00);
      test_random(30);
      write_csr(CSR_POLY, 8'($urandom_range(255)));
      write_csr(CSR_INIT, 8'($urandom_range(255)));
      write_csr(CSR_RETX, 8'h19);
      write_csr(CSR_ACK, 8'h15);
   endtask

   initial begin
      link_cfg = '{crc_polynomial: 8'd7, crc_initial: 8'd0, retransmit_code: 8'd25,
                   ack_code: 8'd21};
      rx_phase = PHASE_LENGTH;
      payload_count = 0;
      running_crc = 8'd0;
      read_slot = 0;
      write_slot = 0;
      for (int i = 0; i < FB; i++) last_sent[i] = 8'h00;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 20;
      recv_idle_pct = 67;
      test_directed();
      test_ring_full();
      test_backpressure();
      test_random(40);
      send_idle_pct = 67;
      recv_idle_pct = 20;
      test_random(40);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_config_sweep();
      test_random(40);
      drain_link();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

### files.f
rtl/core/plr_pkg.sv
rtl/core/plr_ram.sv
rtl/core/plr_rx.sv
rtl/core/plr_seq.sv
rtl/core/packet_link_receiver_with_ack_retransmit_core.sv
rtl/core/plr_checker.sv
bench/tb_packet_link_receiver_with_ack_retransmit_core.sv
